FILE: hw/rtl/moed_pkg.sv
// moed_pkg: shared types and constants for the 3x3 erosion/dilation block.
// No dependencies; imported by moed_window and morphology_erode_dilate_3x3.
`timescale 1ns / 1ps

package moed_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MORPH_MODE   = 3'd0,
    CFG_NEIGHBORHOOD = 3'd1,
    CFG_BINARY_IMAGE = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  // Operating mode seen by the window unit
  typedef struct packed {
    logic dilate;   // 1: window maximum, 0: window minimum
    logic square;   // 1: eight neighbours, 0: four-neighbour cross
    logic binary;   // erosion border is 1 instead of full scale
  } moed_mode_t;

  // Which sides of the output pixel lie inside the frame
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } moed_edge_t;

endpackage

FILE: hw/rtl/moed_ifs.sv
// moed_ifs: valid/ready stream interfaces for the pixel input and result beats.
// Depends on nothing; used by morphology_erode_dilate_3x3.
`timescale 1ns / 1ps

interface moed_in_if #(parameter int PIXEL_BITS = 8) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;
  logic                  flush;

  modport source (output valid, pixel_in, flush, input ready);
  modport sink   (input valid, pixel_in, flush, output ready);
endinterface

interface moed_out_if #(parameter int PIXEL_BITS = 8) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

FILE: hw/rtl/moed_window.sv
// moed_window: 3x3 window columns and the min/max reduction with border fill.
// Depends on moed_pkg (mode and edge structs).
`timescale 1ns / 1ps

module moed_window #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [PIXEL_BITS-1:0] col_top,
  input  logic [PIXEL_BITS-1:0] col_mid,
  input  logic [PIXEL_BITS-1:0] col_bot,
  input  moed_pkg::moed_mode_t  mode,
  input  moed_pkg::moed_edge_t  edge_ok,
  output logic [PIXEL_BITS-1:0] result
);
  import moed_pkg::*;

  localparam int PB = PIXEL_BITS;

  // Two stored columns; the third (right) column is the incoming one
  logic [PB-1:0] ctr_r [3];
  logic [PB-1:0] rgt_r [3];
  logic [PB-1:0] win   [3][3];
  logic [PB-1:0] sel   [3][3];
  logic [PB-1:0] border;
  logic [PB-1:0] acc;

  always_ff @(posedge clk) begin
    if (shift) begin
      ctr_r[0] <= rgt_r[0];
      ctr_r[1] <= rgt_r[1];
      ctr_r[2] <= rgt_r[2];
      rgt_r[0] <= col_top;
      rgt_r[1] <= col_mid;
      rgt_r[2] <= col_bot;
    end
  end

  // Window as it stands after this shift: rows top..bottom, cols left..right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r][0] = ctr_r[r];
      win[r][1] = rgt_r[r];
    end
    win[0][2] = col_top;
    win[1][2] = col_mid;
    win[2][2] = col_bot;
  end

  // Border substitution; unused corners take the center value (neutral)
  always_comb begin
    if (mode.dilate) begin
      border = '0;
    end else if (mode.binary) begin
      border = PB'(1);
    end else begin
      border = '1;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r != 1 && c != 1 && !mode.square) begin
          sel[r][c] = win[1][1];
        end else if ((r == 0 && !edge_ok.top_ok) || (r == 2 && !edge_ok.bot_ok) ||
                     (c == 0 && !edge_ok.left_ok) || (c == 2 && !edge_ok.right_ok)) begin
          sel[r][c] = border;
        end else begin
          sel[r][c] = win[r][c];
        end
      end
    end
  end

  // Min or max over the nine candidates
  always_comb begin
    acc = sel[1][1];
    for (int k = 0; k < 9; k++) begin
      if (mode.dilate) begin
        if (sel[k/3][k%3] > acc) acc = sel[k/3][k%3];
      end else begin
        if (sel[k/3][k%3] < acc) acc = sel[k/3][k%3];
      end
    end
  end

  assign result = acc;

endmodule

FILE: hw/rtl/morphology_erode_dilate_3x3.sv
// morphology_erode_dilate_3x3: top level, line store, position counters, output stage.
// Depends on moed_pkg, moed_ifs (moed_in_if, moed_out_if) and moed_window.
`timescale 1ns / 1ps

// 3x3 erosion (minimum) or dilation (maximum) over a raster pixel stream, with
// a four-neighbour cross or a full eight-neighbour square. Pixels outside the
// frame read as 0 for dilation and full scale (1 for binary images) for
// erosion. One beat enters per clock and one result leaves per clock while the
// output is not stalled: each beat does a single read of the line store at its
// column and writes that column back when it leaves stage 1, so the memory port
// sets the rate of one beat a cycle; a beat's result passes through stage 1 and
// the output register. Results trail the input by one row plus one pixel, so
// after the last pixel of a frame the host sends image_width+1 flush beats;
// frame_last marks the final result, after which a new frame begins. Writing
// image_width or image_height also restarts the frame. The user must write
// configuration only while the block is idle; the block does not enforce it.
// The line store needs no clearing after reset.
module morphology_erode_dilate_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  moed_in_if.sink                         in_ch,
  moed_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [moed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [moed_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import moed_pkg::*;

  localparam int PB    = PIXEL_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  // Configuration state
  moed_mode_t    mode_r;
  logic [CW-1:0] w_last_r, w_last_nxt;
  logic [HW-1:0] h_r, h_nxt;

  // Position of the next beat
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Stage 1: beat whose line store read is in flight
  logic          s1_valid_r;
  logic [CW-1:0] s1_addr_r;
  logic [PB-1:0] s1_pix_r;
  logic          s1_emit_r;
  logic          s1_last_r;
  moed_edge_t    s1_edge_r;

  // Line store: {upper row, middle row} per column
  logic [2*PB-1:0] mem [MAX_WIDTH];
  logic [2*PB-1:0] rdata_r;
  logic            fwd_valid_r;
  logic [CW-1:0]   fwd_addr_r;
  logic [2*PB-1:0] fwd_data_r;
  logic [2*PB-1:0] line_now;
  logic [2*PB-1:0] wdata;

  // Output register
  logic          out_valid_r;
  logic [PB-1:0] out_pix_r;
  logic          out_last_r;

  // Stage 0 decode
  logic          in_ready;
  logic          in_fire;
  logic          adv1;
  logic          s1_go;
  logic          col0;
  logic          row_in_frame;
  logic [PB-1:0] s0_pix;
  logic          s0_emit;
  logic          s0_last;
  moed_edge_t    s0_edge;
  logic [PB-1:0] win_result;
  logic          size_write;

  // Clamped frame size from the write data
  always_comb begin
    if (cfg_wdata == '0) begin
      w_last_nxt = '0;
    end else if (32'(cfg_wdata) > MAX_WIDTH) begin
      w_last_nxt = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_nxt = CW'(cfg_wdata - CFG_DATA_W'(1));
    end
    if (cfg_wdata == '0) begin
      h_nxt = HW'(1);
    end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
      h_nxt = HW'(MAX_HEIGHT);
    end else begin
      h_nxt = HW'(cfg_wdata);
    end
  end

  assign size_write = cfg_we && (cfg_reg_t'(cfg_index) == CFG_IMAGE_WIDTH ||
                                 cfg_reg_t'(cfg_index) == CFG_IMAGE_HEIGHT);

  // Handshake: stage 1 moves when the output register is free or draining
  assign adv1     = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && adv1;
  assign in_ready = !s1_valid_r || adv1;
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Stage 0: pixel value, result position flags, next position
  always_comb begin
    col0         = (col_r == '0);
    row_in_frame = 32'(row_r) < 32'(h_r);
    s0_pix       = (!in_ch.flush && row_in_frame) ? in_ch.pixel_in : '0;
    s0_emit      = (row_r >= RW'(2)) || (row_r == RW'(1) && !col0);
    s0_edge.top_ok   = col0 ? (row_r > RW'(2)) : (row_r > RW'(1));
    s0_edge.bot_ok   = col0 ? (32'(row_r) <= 32'(h_r)) : row_in_frame;
    s0_edge.left_ok  = col0 ? (w_last_r != '0) : (col_r > CW'(1));
    s0_edge.right_ok = !col0;
    s0_last      = s0_emit && col0 && (32'(row_r) > 32'(h_r));
    if (s0_last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_r == w_last_r) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  // Config registers, position counters, pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      w_last_r    <= CW'(W_RST - 1);
      h_r         <= HW'(H_RST);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MORPH_MODE:   mode_r.dilate <= cfg_wdata[0];
          CFG_NEIGHBORHOOD: mode_r.square <= cfg_wdata[0];
          CFG_BINARY_IMAGE: mode_r.binary <= cfg_wdata[0];
          CFG_IMAGE_WIDTH:  w_last_r      <= w_last_nxt;
          CFG_IMAGE_HEIGHT: h_r           <= h_nxt;
          default: ;
        endcase
      end
      if (size_write) begin
        col_r <= '0;
        row_r <= '0;
      end else if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        fwd_valid_r <= 1'b1;
        out_valid_r <= s1_emit_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage 1 payload, forwarding copy and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= col_r;
      s1_pix_r  <= s0_pix;
      s1_emit_r <= s0_emit;
      s1_last_r <= s0_last;
      s1_edge_r <= s0_edge;
    end
    if (s1_go) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= wdata;
    end
    if (s1_go && s1_emit_r) begin
      out_pix_r  <= win_result;
      out_last_r <= s1_last_r;
    end
  end

  // Read-modify-write of the line store; a one-column frame hits the
  // same entry on consecutive beats, so the last write is forwarded
  assign line_now = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rdata_r;
  assign wdata    = {line_now[PB-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem[s1_addr_r] <= wdata;
    end
    if (in_fire) begin
      rdata_r <= mem[col_r];
    end
  end

  moed_window #(
    .PIXEL_BITS (PB)
  ) u_window (
    .clk     (clk),
    .shift   (s1_go),
    .col_top (line_now[2*PB-1:PB]),
    .col_mid (line_now[PB-1:0]),
    .col_bot (s1_pix_r),
    .mode    (mode_r),
    .edge_ok (s1_edge_r),
    .result  (win_result)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_out  = out_pix_r;
  assign out_ch.frame_last = out_last_r;

  // Checks
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last_r)
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) <= 32'(h_r) + 1)
    else $error("row counter beyond last flush row");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && s0_last |=> col_r == '0 && row_r == '0)
    else $error("frame did not restart after its final pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r |-> s1_emit_r)
    else $error("frame end marked on a beat without a result");

endmodule
